@@ design/assert_macros.svh @@
// Assertion helpers used by the mix engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define ASSERT_STEP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ design/mvpm_pkg.sv @@
package mvpm_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  // Mix sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } back_state_e;

  localparam int LEN_W  = 13;
  localparam int GAIN_W = 17;
  localparam int ACC_W  = 54;

  localparam logic [GAIN_W-1:0] UNITY_Q16 = 17'd65536;
  localparam logic [13:0]       PAN_FULL  = 14'd10000;
  // floor(x * 4096 / 625) == (x * PAN_RECIP) >> PAN_SHIFT for x <= 10000
  localparam logic [25:0]       PAN_RECIP = 26'd54975582;
  localparam int                PAN_SHIFT = 23;

  localparam int FIFO_DEPTH = 4;

  // Command passed from the front end to the mix engine
  typedef struct packed {
    mode_e                op;
    logic [3:0]           voice;
    logic [11:0]          frame;
    logic signed [15:0]   left;
    logic signed [15:0]   right;
    logic [LEN_W-1:0]     len;
    logic                 loop;
    logic [GAIN_W-1:0]    vol;
    logic [GAIN_W-1:0]    gain_l;
    logic [GAIN_W-1:0]    gain_r;
  } cmd_t;

  // Truncate toward zero by 2^32 (stereo) or 2^33 (mono), then clamp to 16 bits
  function automatic logic signed [15:0] trunc_sat(input logic signed [ACC_W:0] v,
                                                   input logic mono);
    logic signed [ACC_W:0] adj;
    logic signed [ACC_W:0] q;
    adj = v;
    if (v < 0) begin
      adj = mono ? v + (ACC_W+1)'(64'h1_FFFF_FFFF) : v + (ACC_W+1)'(64'hFFFF_FFFF);
    end
    q = mono ? (adj >>> 33) : (adj >>> 32);
    if (q > 32767) begin
      return 16'sh7FFF;
    end else if (q < -32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

endpackage

@@ design/mvpm_ram.sv @@
module mvpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mvpm_front.sv @@
module mvpm_front import mvpm_pkg::*; #(
  parameter int VOICES           = 16,
  parameter int FRAMES_PER_VOICE = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         voice_i,
  input  logic [11:0]        frame_index_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic [12:0]        frame_count_i,
  input  logic               loop_enable_i,
  input  logic [16:0]        volume_gain_i,
  input  logic signed [14:0] pan_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_full_i
);

  // Stage 1: captured item
  logic               r1_v_q;
  mode_e              mode_q;
  logic [3:0]         voice_q;
  logic [11:0]        frame_q;
  logic signed [15:0] left_q, right_q;
  logic [12:0]        count_q;
  logic               loop_q;
  logic [16:0]        vol_q;
  logic signed [14:0] pan_q;

  // Stage 2: classified command with pan product
  logic        r2_v_q;
  cmd_t        r2_q;
  logic [39:0] prod_q;
  logic        pos_q, neg_q;

  logic               push, advance, keep;
  logic signed [14:0] pan_c;
  logic [13:0]        amount;
  logic [13:0]        keep_x;
  logic [39:0]        prod_d;
  cmd_t               cmd_d;
  logic [GAIN_W-1:0]  gain;

  assign push       = r2_v_q && !cmd_full_i;
  assign advance    = r1_v_q && (!r2_v_q || push);
  assign in_stall_o = r1_v_q && !advance;

  // Classify, clamp and form the pan product
  always_comb begin
    pan_c = pan_q;
    if (pan_q > 15'sd10000) begin
      pan_c = 15'sd10000;
    end else if (pan_q < -15'sd10000) begin
      pan_c = -15'sd10000;
    end
    amount = pan_c[14] ? 14'(-pan_c) : 14'(pan_c);
    keep_x = PAN_FULL - amount;
    prod_d = 40'(keep_x) * 40'(PAN_RECIP);

    keep = (mode_q == MODE_TICK) || (32'(voice_q) < VOICES);
    if (mode_q == MODE_LOAD && !(32'(frame_q) < FRAMES_PER_VOICE)) begin
      keep = 1'b0;
    end

    cmd_d        = '0;
    cmd_d.op     = mode_q;
    cmd_d.voice  = voice_q;
    cmd_d.frame  = frame_q;
    cmd_d.left   = left_q;
    cmd_d.right  = right_q;
    cmd_d.len    = (32'(count_q) > FRAMES_PER_VOICE) ? LEN_W'(FRAMES_PER_VOICE) : count_q;
    cmd_d.loop   = loop_q;
    cmd_d.vol    = (vol_q > UNITY_Q16) ? UNITY_Q16 : vol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      r1_v_q <= 1'b1;
    end else if (advance) begin
      r1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q  <= mode_e'(mode_i);
      voice_q <= voice_i;
      frame_q <= frame_index_i;
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
      count_q <= frame_count_i;
      loop_q  <= loop_enable_i;
      vol_q   <= volume_gain_i;
      pan_q   <= pan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_v_q <= 1'b0;
    end else if (advance) begin
      r2_v_q <= keep;
    end else if (push) begin
      r2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r2_q   <= cmd_d;
      prod_q <= prod_d;
      pos_q  <= (pan_c > 15'sd0);
      neg_q  <= pan_c[14];
    end
  end

  // Gains from the registered product
  always_comb begin
    gain          = prod_q[PAN_SHIFT +: GAIN_W];
    cmd_o         = r2_q;
    cmd_o.gain_l  = pos_q ? gain : UNITY_Q16;
    cmd_o.gain_r  = neg_q ? gain : UNITY_Q16;
  end

  assign cmd_valid_o = push;

endmodule

@@ design/mvpm_fifo.sv @@
module mvpm_fifo import mvpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t          q_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = q_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_q] <= data_i;
    end
  end

endmodule

@@ design/mvpm_back.sv @@
`include "assert_macros.svh"

module mvpm_back import mvpm_pkg::*; #(
  parameter int VOICES           = 16,
  parameter int FRAMES_PER_VOICE = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o
);

  localparam int VI_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ADDR_W = $clog2(VOICES * FRAMES_PER_VOICE);

  back_state_e state_q, state_d;
  logic [1:0]  chan_q;

  // Per-voice state
  logic              act_q  [VOICES];
  logic              loop_q [VOICES];
  logic [LEN_W-1:0]  cur_q  [VOICES];
  logic [LEN_W-1:0]  len_q  [VOICES];
  logic [GAIN_W-1:0] vol_q  [VOICES];
  logic [GAIN_W-1:0] gl_q   [VOICES];
  logic [GAIN_W-1:0] gr_q   [VOICES];

  logic [VI_W-1:0] scan_q;

  // Mix pipeline
  logic                     rd_v_q, m1_v_q, m2_v_q;
  logic [GAIN_W-1:0]        rd_vol_q, rd_gl_q, rd_gr_q, m1_gl_q, m1_gr_q;
  logic signed [33:0]       m1l_q, m1r_q;
  logic signed [51:0]       m2l_q, m2r_q;
  logic signed [ACC_W-1:0]  accl_q, accr_q;

  logic                     out_valid_q;
  logic signed [15:0]       left_q, right_q;

  logic              live, ended, use_v, emit;
  logic [LEN_W-1:0]  rd_cur;
  logic [VI_W-1:0]   cvi;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_rdata;
  logic signed [15:0] sl, sr;
  logic signed [ACC_W:0] sum_l, sum_r, sum_m;
  logic              mono;

  assign cfg_ready_o = 1'b1;
  assign mono        = !chan_q[1];
  assign cvi         = VI_W'(cmd_i.voice);
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Voice visit decision
  always_comb begin
    live   = act_q[scan_q] && (len_q[scan_q] != '0);
    ended  = cur_q[scan_q] >= len_q[scan_q];
    use_v  = (state_q == ST_SCAN) && live && (!ended || loop_q[scan_q]);
    rd_cur = ended ? '0 : cur_q[scan_q];
  end

  // Sample store access
  assign ram_we    = cmd_pop_o && (cmd_i.op == MODE_LOAD);
  assign ram_waddr = ADDR_W'(cmd_i.voice) * ADDR_W'(FRAMES_PER_VOICE) + ADDR_W'(cmd_i.frame);
  assign ram_re    = use_v;
  assign ram_raddr = ADDR_W'(scan_q) * ADDR_W'(FRAMES_PER_VOICE) + ADDR_W'(rd_cur);

  mvpm_ram #(
    .WIDTH (32),
    .DEPTH (VOICES * FRAMES_PER_VOICE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({cmd_i.right, cmd_i.left}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sl = ram_rdata[15:0];
  assign sr = ram_rdata[31:16];

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && cmd_i.op == MODE_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == VI_W'(VOICES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !m1_v_q && !m2_v_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= 2'd2;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        chan_q <= cfg_data_i;
      end
      if (state_q == ST_IDLE) begin
        scan_q <= '0;
      end else if (state_q == ST_SCAN && scan_q != VI_W'(VOICES - 1)) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  // Voice table updates: commands and tick visits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        act_q[i]  <= 1'b0;
        loop_q[i] <= 1'b0;
        cur_q[i]  <= '0;
        len_q[i]  <= '0;
        vol_q[i]  <= '0;
        gl_q[i]   <= UNITY_Q16;
        gr_q[i]   <= UNITY_Q16;
      end
    end else if (cmd_pop_o) begin
      case (cmd_i.op)
        MODE_START: begin
          act_q[cvi]  <= 1'b1;
          loop_q[cvi] <= cmd_i.loop;
          cur_q[cvi]  <= '0;
          len_q[cvi]  <= cmd_i.len;
          vol_q[cvi]  <= cmd_i.vol;
          gl_q[cvi]   <= cmd_i.gain_l;
          gr_q[cvi]   <= cmd_i.gain_r;
        end
        MODE_STOP: act_q[cvi] <= 1'b0;
        default: ;
      endcase
    end else if (state_q == ST_SCAN && live) begin
      if (ended && !loop_q[scan_q]) begin
        act_q[scan_q] <= 1'b0;
      end else begin
        cur_q[scan_q] <= rd_cur + 1'b1;
      end
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else begin
      rd_v_q <= use_v;
      m1_v_q <= rd_v_q;
      m2_v_q <= m1_v_q;
    end
  end

  // Sample times volume, then times gain, then accumulate
  always_ff @(posedge clk_i) begin
    if (use_v) begin
      rd_vol_q <= vol_q[scan_q];
      rd_gl_q  <= gl_q[scan_q];
      rd_gr_q  <= gr_q[scan_q];
    end
    if (rd_v_q) begin
      m1l_q   <= sl * $signed({1'b0, rd_vol_q});
      m1r_q   <= sr * $signed({1'b0, rd_vol_q});
      m1_gl_q <= rd_gl_q;
      m1_gr_q <= rd_gr_q;
    end
    if (m1_v_q) begin
      m2l_q <= m1l_q * $signed({1'b0, m1_gl_q});
      m2r_q <= m1r_q * $signed({1'b0, m1_gr_q});
    end
    if (cmd_pop_o && cmd_i.op == MODE_TICK) begin
      accl_q <= '0;
      accr_q <= '0;
    end else if (m2_v_q) begin
      accl_q <= accl_q + ACC_W'(m2l_q);
      accr_q <= accr_q + ACC_W'(m2r_q);
    end
  end

  // Output frame
  assign sum_l = (ACC_W+1)'(accl_q);
  assign sum_r = (ACC_W+1)'(accr_q);
  assign sum_m = sum_l + sum_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      left_q  <= mono ? trunc_sat(sum_m, 1'b1) : trunc_sat(sum_l, 1'b0);
      right_q <= mono ? 16'sd0 : trunc_sat(sum_r, 1'b0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

  `ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "mix sequencer state not one-hot")
  `ASSERT_ALWAYS(a_emit_drained, (state_q == ST_EMIT) |-> (!rd_v_q && !m1_v_q && !m2_v_q), "emit with products in flight")
  `ASSERT_STEP(a_emit_valid, emit, out_valid_q, "emitted frame not presented")
  `ASSERT_STEP(a_scan_no_pop, state_q == ST_SCAN, !m2_v_q || state_q != ST_IDLE, "idle with products in flight")

endmodule

@@ design/multi_voice_pcm_mixer.sv @@
// A tick result is presented after the mix engine has scanned all VOICES voices, drained
// the product pipeline and registered the output frame; load, start and stop give no result.
// The voice scan reads at most one sample store word per cycle. The mix engine pops no
// further command until a tick's frame is emitted; later items wait in the command queue,
// and in_stall_o rises once the queue and the front end are full.
// Reset: asynchronous active low; voices idle, gains at unity, stereo output.
// The sample store is not cleared and reads as unknown until written.
module multi_voice_pcm_mixer import mvpm_pkg::*; #(
  parameter int VOICES           = 16,
  parameter int FRAMES_PER_VOICE = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         voice_i,
  input  logic [11:0]        frame_index_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic [12:0]        frame_count_i,
  input  logic               loop_enable_i,
  input  logic [16:0]        volume_gain_i,
  input  logic signed [14:0] pan_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  // Front end: capture, clamp, pan gains
  mvpm_front #(
    .VOICES           (VOICES),
    .FRAMES_PER_VOICE (FRAMES_PER_VOICE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .voice_i        (voice_i),
    .frame_index_i  (frame_index_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .frame_count_i  (frame_count_i),
    .loop_enable_i  (loop_enable_i),
    .volume_gain_i  (volume_gain_i),
    .pan_i          (pan_i),
    .cmd_valid_o    (cmd_push),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full)
  );

  // Command queue
  mvpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  // Mix engine
  mvpm_back #(
    .VOICES           (VOICES),
    .FRAMES_PER_VOICE (FRAMES_PER_VOICE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

endmodule
